// ----- hdl/lrf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared widths, codes and item types of the LCD rectangle fill sequencer.
// ----------------------------------------------------------------------------
package lrf_pkg;

   // field widths
   localparam int unsigned COORD_W     = 10;
   localparam int unsigned SIZE_W      = 11;
   localparam int unsigned COLOR_W     = 16;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned PIXELS_W    = 21;
   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned FRAME_POS_W = 3;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 11;

   // register reset values
   localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = SIZE_W'(320);
   localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = SIZE_W'(240);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = CSR_INDEX_W'(1);

   // item command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_SLOT  = 1'b1;

   // panel opcodes
   localparam logic [BYTE_W-1:0] OPC_COLUMN_ADDR  = 8'h2A;
   localparam logic [BYTE_W-1:0] OPC_ROW_ADDR     = 8'h2B;
   localparam logic [BYTE_W-1:0] OPC_MEMORY_WRITE = 8'h2C;

   // byte positions inside an address frame
   localparam logic [FRAME_POS_W-1:0] FRAME_OPCODE   = FRAME_POS_W'(0);
   localparam logic [FRAME_POS_W-1:0] FRAME_START_HI = FRAME_POS_W'(1);
   localparam logic [FRAME_POS_W-1:0] FRAME_START_LO = FRAME_POS_W'(2);
   localparam logic [FRAME_POS_W-1:0] FRAME_END_HI   = FRAME_POS_W'(3);
   localparam logic [FRAME_POS_W-1:0] FRAME_END_LO   = FRAME_POS_W'(4);

   typedef struct packed {
      logic               command;
      logic [COORD_W-1:0] rect_x;
      logic [COORD_W-1:0] rect_y;
      logic [SIZE_W-1:0]  rect_width;
      logic [SIZE_W-1:0]  rect_height;
      logic [COLOR_W-1:0] fill_color;
   } lrf_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] link_byte;
      logic              is_command;
      logic              frame_end;
      logic              last;
   } lrf_result_type;

   typedef struct packed {
      logic [SIZE_W-1:0] screen_width;
      logic [SIZE_W-1:0] screen_height;
   } lrf_cfg_type;

   typedef struct packed {
      logic busy;
   } lrf_seq_status_type;

endpackage
`default_nettype wire

// ----- hdl/lrf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_if
// Valid/ready channels of the rectangle fill sequencer: request items,
// response bytes and register writes.
// ----------------------------------------------------------------------------
interface lrf_req_if import lrf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [COORD_W-1:0] rect_x;
   logic [COORD_W-1:0] rect_y;
   logic [SIZE_W-1:0]  rect_width;
   logic [SIZE_W-1:0]  rect_height;
   logic [COLOR_W-1:0] fill_color;

   modport source (output valid, command, rect_x, rect_y, rect_width, rect_height,
                   fill_color, input ready);
   modport sink   (input valid, command, rect_x, rect_y, rect_width, rect_height,
                   fill_color, output ready);
endinterface

interface lrf_rsp_if import lrf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] link_byte;
   logic              is_command;
   logic              frame_end;
   logic              last;

   modport source (output valid, link_byte, is_command, frame_end, last, input ready);
   modport sink   (input valid, link_byte, is_command, frame_end, last, output ready);
endinterface

interface lrf_csr_if import lrf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/lrf_csr_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_csr_regs
// Panel size registers used for the full-screen window restore.
// ----------------------------------------------------------------------------
module lrf_csr_regs import lrf_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   lrf_csr_if.sink    csr_bus,
   output lrf_cfg_type cfg
);

   logic [SIZE_W-1:0] screen_width_ff,  screen_width_in;
   logic [SIZE_W-1:0] screen_height_ff, screen_height_in;
   logic              wr_en;

   // always take writes
   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;

   // decode the register index; unknown indexes are dropped
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (wr_en) begin
         unique case (csr_bus.index)
            CSR_SCREEN_WIDTH:  screen_width_in  = SIZE_W'(csr_bus.data);
            CSR_SCREEN_HEIGHT: screen_height_in = SIZE_W'(csr_bus.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   assign cfg.screen_width  = screen_width_ff;
   assign cfg.screen_height = screen_height_ff;

endmodule
`default_nettype wire

// ----- hdl/lrf_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_seq
// Fill sequencer: holds the rectangle and walks the column, row, memory
// write and restore frames, one byte per accepted slot item.
// ----------------------------------------------------------------------------
module lrf_seq import lrf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  lrf_item_type       item,
   input  lrf_cfg_type        cfg,
   output logic               res_valid,
   output lrf_result_type     res,
   output lrf_seq_status_type stat
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_COL,
      PH_ROW,
      PH_MEM,
      PH_RCOL,
      PH_RROW
   } phase_type;

   phase_type               phase_ff,      phase_in;
   logic [FRAME_POS_W-1:0]  byte_pos_ff,   byte_pos_in;
   logic [PIXELS_W-1:0]     pixels_left_ff, pixels_left_in;
   logic                    low_byte_ff,   low_byte_in;
   logic [COORD_W-1:0]      x_ff,   x_in;
   logic [COORD_W-1:0]      y_ff,   y_in;
   logic [COORD_W-1:0]      wm1_ff, wm1_in;
   logic [COORD_W-1:0]      hm1_ff, hm1_in;
   logic [COLOR_W-1:0]      color_ff, color_in;

   logic [SIZE_W-1:0]       width_sub, height_sub;
   logic [SIZE_W-1:0]       width_full, height_full;
   logic [2*SIZE_W-1:0]     pixel_product;
   logic [ADDR_W-1:0]       addr_start, addr_end, addr_sel;

   // size-minus-one as held, keeping the low 10 bits
   assign width_sub  = item.rect_width  - SIZE_W'(1);
   assign height_sub = item.rect_height - SIZE_W'(1);

   // pixel count of the held rectangle
   assign width_full    = {1'b0, wm1_ff} + SIZE_W'(1);
   assign height_full   = {1'b0, hm1_ff} + SIZE_W'(1);
   assign pixel_product = width_full * height_full;

   // window bounds of the current address frame
   always_comb begin
      addr_start = '0;
      addr_end   = '0;
      unique case (phase_ff)
         PH_COL: begin
            addr_start = ADDR_W'(x_ff);
            addr_end   = ADDR_W'({1'b0, x_ff} + {1'b0, wm1_ff});
         end
         PH_ROW: begin
            addr_start = ADDR_W'(y_ff);
            addr_end   = ADDR_W'({1'b0, y_ff} + {1'b0, hm1_ff});
         end
         PH_RCOL: addr_end = ADDR_W'(cfg.screen_width) - ADDR_W'(1);
         PH_RROW: addr_end = ADDR_W'(cfg.screen_height) - ADDR_W'(1);
         default: ;
      endcase
      addr_sel = (byte_pos_ff <= FRAME_START_LO) ? addr_start : addr_end;
   end

   // next state and result byte
   always_comb begin
      phase_in       = phase_ff;
      byte_pos_in    = byte_pos_ff;
      pixels_left_in = pixels_left_ff;
      low_byte_in    = low_byte_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      wm1_in         = wm1_ff;
      hm1_in         = hm1_ff;
      color_in       = color_ff;
      res_valid      = 1'b0;
      res            = '0;

      if (step_en) begin
         if (item.command == CMD_START) begin
            // latch a new rectangle; drop the start while busy
            if (phase_ff == PH_IDLE) begin
               x_in           = item.rect_x;
               y_in           = item.rect_y;
               wm1_in         = width_sub[COORD_W-1:0];
               hm1_in         = height_sub[COORD_W-1:0];
               color_in       = item.fill_color;
               phase_in       = PH_COL;
               byte_pos_in    = FRAME_OPCODE;
               pixels_left_in = '0;
               low_byte_in    = 1'b0;
            end
         end else if (phase_ff == PH_MEM) begin
            res_valid = 1'b1;
            if (byte_pos_ff == FRAME_OPCODE) begin
               res.link_byte  = OPC_MEMORY_WRITE;
               res.is_command = 1'b1;
               pixels_left_in = pixel_product[PIXELS_W-1:0];
               low_byte_in    = 1'b0;
               byte_pos_in    = FRAME_START_HI;
            end else if (!low_byte_ff) begin
               res.link_byte = color_ff[COLOR_W-1:BYTE_W];
               low_byte_in   = 1'b1;
            end else begin
               // low byte closes a pixel; the last one closes the frame
               res.link_byte  = color_ff[BYTE_W-1:0];
               low_byte_in    = 1'b0;
               pixels_left_in = pixels_left_ff - PIXELS_W'(1);
               if (pixels_left_ff == PIXELS_W'(1)) begin
                  res.frame_end = 1'b1;
                  phase_in      = PH_RCOL;
                  byte_pos_in   = FRAME_OPCODE;
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            res_valid = 1'b1;
            if (byte_pos_ff == FRAME_OPCODE) begin
               res.link_byte  = (phase_ff == PH_COL || phase_ff == PH_RCOL) ?
                                OPC_COLUMN_ADDR : OPC_ROW_ADDR;
               res.is_command = 1'b1;
               byte_pos_in    = FRAME_START_HI;
            end else begin
               res.link_byte = (byte_pos_ff == FRAME_START_HI ||
                                byte_pos_ff == FRAME_END_HI) ?
                               addr_sel[ADDR_W-1:BYTE_W] : addr_sel[BYTE_W-1:0];
               if (byte_pos_ff >= FRAME_END_LO) begin
                  res.frame_end = 1'b1;
                  byte_pos_in   = FRAME_OPCODE;
                  unique case (phase_ff)
                     PH_COL:  phase_in = PH_ROW;
                     PH_ROW:  phase_in = PH_MEM;
                     PH_RCOL: phase_in = PH_RROW;
                     default: begin
                        res.last = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  endcase
               end else begin
                  byte_pos_in = byte_pos_ff + FRAME_POS_W'(1);
               end
            end
         end
      end
   end

   // hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_pos_ff    <= FRAME_OPCODE;
         pixels_left_ff <= '0;
         low_byte_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         byte_pos_ff    <= byte_pos_in;
         pixels_left_ff <= pixels_left_in;
         low_byte_ff    <= low_byte_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      wm1_ff   <= wm1_in;
      hm1_ff   <= hm1_in;
      color_ff <= color_in;
   end

   assign stat.busy = (phase_ff != PH_IDLE);

endmodule
`default_nettype wire

// ----- hdl/lcd_rect_fill_sequencer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_rect_fill_sequencer_unit
// Turns a rectangle fill request into the SPI byte stream of a panel fill.
//
// Channels: req_bus takes items; command CMD_START latches a rectangle and
// colour and gives no response, command CMD_SLOT asks for the next byte.
// rsp_bus returns one byte per slot while a fill runs, tagged as command or
// data, with frame_end where chip select rises and last on the final byte.
// Slots while idle give no response; a start while busy is dropped.
// csr_bus writes the panel width (index 0) and height (index 1) used for the
// full-screen window restore; it is always ready.
// Bytes are registered: one shows on rsp_bus in the cycle after its slot is
// accepted. Throughput: one item per cycle while rsp_bus.ready is high or
// the response register is empty; the step logic from the sequencer state
// to that register is combinational, one 11x11 pixel-count multiply at most.
// Reset: synchronous; the sequencer goes idle, the panel size returns to
// 320 x 240 and the response register empties.
// Stall: a held response blocks new items only when rsp_bus.ready is low.
// ----------------------------------------------------------------------------
module lcd_rect_fill_sequencer_unit import lrf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   lrf_req_if.sink   req_bus,
   lrf_rsp_if.source rsp_bus,
   lrf_csr_if.sink   csr_bus
);

   lrf_cfg_type        cfg;
   lrf_item_type       item;
   lrf_result_type     seq_res;
   lrf_seq_status_type seq_stat;
   logic               seq_res_valid;
   logic               req_fire;
   logic               out_load;
   logic               rsp_valid_ff, rsp_valid_in;
   lrf_result_type     rsp_data_ff,  rsp_data_in;

   lrf_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // pack the request item
   assign item.command     = req_bus.command;
   assign item.rect_x      = req_bus.rect_x;
   assign item.rect_y      = req_bus.rect_y;
   assign item.rect_width  = req_bus.rect_width;
   assign item.rect_height = req_bus.rect_height;
   assign item.fill_color  = req_bus.fill_color;

   // accept while the response register is free or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   lrf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_fire),
      .item      (item),
      .cfg       (cfg),
      .res_valid (seq_res_valid),
      .res       (seq_res),
      .stat      (seq_stat)
   );

   // response register: load a new byte, drop a taken one
   assign out_load = req_fire && seq_res_valid;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.link_byte  = rsp_data_ff.link_byte;
   assign rsp_bus.is_command = rsp_data_ff.is_command;
   assign rsp_bus.frame_end  = rsp_data_ff.frame_end;
   assign rsp_bus.last       = rsp_data_ff.last;

`ifndef SYNTH
   // only slot items produce bytes
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (req_bus.command == CMD_SLOT))
      else $error("response loaded from a start item");

   // the final byte of a fill leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      (out_load && seq_res.last) |=> !seq_stat.busy)
      else $error("sequencer still busy after final byte");

   // the final byte always closes a frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.last) |-> rsp_bus.frame_end)
      else $error("final byte without frame end");

   // command bytes are panel opcodes only
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.is_command) |->
         (rsp_bus.link_byte == OPC_COLUMN_ADDR || rsp_bus.link_byte == OPC_ROW_ADDR ||
          rsp_bus.link_byte == OPC_MEMORY_WRITE))
      else $error("command byte is not an opcode");
`endif

endmodule
`default_nettype wire

// ----- verif/lrf_stream_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_stream_check
// Watches the request, response and register channels of the rectangle fill
// sequencer. It keeps its own copy of the sequencer state and panel size, works
// out the byte that each accepted slot must give, and compares every accepted
// response byte with the oldest byte still owed.
// ----------------------------------------------------------------------------
module lrf_stream_check import lrf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   lrf_req_if        req_mon,
   lrf_rsp_if        rsp_mon,
   lrf_csr_if        csr_mon,
   output int        failures,
   output int        owed_bytes
);

   typedef enum logic [2:0] {
      FILL_IDLE,
      FILL_COLUMN,
      FILL_ROW,
      FILL_PIXELS,
      FILL_COLUMN_RESTORE,
      FILL_ROW_RESTORE
   } fill_phase_type;

   // shadow of the sequencer
   fill_phase_type         phase_q;
   logic [FRAME_POS_W-1:0] frame_pos;
   logic [PIXELS_W-1:0]    pixels_left;
   logic                   low_half_next;
   logic [COORD_W-1:0]     win_x;
   logic [COORD_W-1:0]     win_y;
   logic [COORD_W-1:0]     win_wm1;
   logic [COORD_W-1:0]     win_hm1;
   logic [COLOR_W-1:0]     color_q;
   logic [SIZE_W-1:0]      panel_width;
   logic [SIZE_W-1:0]      panel_height;

   lrf_result_type         owed_queue[$];

   task automatic report_mismatch(input string what);
      $display("check failed at %0t ns: %s", $time, what);
      failures++;
   endtask

   // Advance the shadow by one item; return 1 with the byte the item must give.
   function automatic bit next_link_byte(input lrf_item_type it, output lrf_result_type res);
      logic [SIZE_W-1:0] size_m1;
      logic [ADDR_W-1:0] first_addr;
      logic [ADDR_W-1:0] last_addr;
      logic [ADDR_W-1:0] word;
      res        = '0;
      first_addr = '0;
      last_addr  = '0;

      // latch a new rectangle only when idle
      if (it.command == CMD_START) begin
         if (phase_q == FILL_IDLE) begin
            win_x         = it.rect_x;
            win_y         = it.rect_y;
            size_m1       = it.rect_width - 1'b1;
            win_wm1       = size_m1[COORD_W-1:0];
            size_m1       = it.rect_height - 1'b1;
            win_hm1       = size_m1[COORD_W-1:0];
            color_q       = it.fill_color;
            phase_q       = FILL_COLUMN;
            frame_pos     = FRAME_OPCODE;
            pixels_left   = '0;
            low_half_next = 1'b0;
         end
         return 1'b0;
      end

      if (phase_q == FILL_IDLE)
         return 1'b0;

      // memory write frame: opcode, then colour pairs high byte first
      if (phase_q == FILL_PIXELS) begin
         if (frame_pos == FRAME_OPCODE) begin
            res.link_byte  = OPC_MEMORY_WRITE;
            res.is_command = 1'b1;
            pixels_left    = (PIXELS_W'(win_wm1) + PIXELS_W'(1)) *
                             (PIXELS_W'(win_hm1) + PIXELS_W'(1));
            low_half_next  = 1'b0;
            frame_pos      = FRAME_START_HI;
         end else if (!low_half_next) begin
            res.link_byte = color_q[15:8];
            low_half_next = 1'b1;
         end else begin
            res.link_byte = color_q[7:0];
            low_half_next = 1'b0;
            pixels_left   = pixels_left - 1'b1;
            if (pixels_left == '0) begin
               res.frame_end = 1'b1;
               phase_q       = FILL_COLUMN_RESTORE;
               frame_pos     = FRAME_OPCODE;
            end
         end
         return 1'b1;
      end

      // address frames: window of the rectangle, then the full-screen restore
      case (phase_q)
         FILL_COLUMN: begin
            first_addr = ADDR_W'(win_x);
            last_addr  = ADDR_W'(win_x) + ADDR_W'(win_wm1);
         end
         FILL_ROW: begin
            first_addr = ADDR_W'(win_y);
            last_addr  = ADDR_W'(win_y) + ADDR_W'(win_hm1);
         end
         FILL_COLUMN_RESTORE: begin
            last_addr = ADDR_W'(panel_width) - ADDR_W'(1);
         end
         default: begin
            last_addr = ADDR_W'(panel_height) - ADDR_W'(1);
         end
      endcase

      if (frame_pos == FRAME_OPCODE) begin
         res.link_byte  = (phase_q == FILL_COLUMN || phase_q == FILL_COLUMN_RESTORE) ?
                          OPC_COLUMN_ADDR : OPC_ROW_ADDR;
         res.is_command = 1'b1;
         frame_pos      = FRAME_START_HI;
      end else begin
         word          = (frame_pos <= FRAME_START_LO) ? first_addr : last_addr;
         res.link_byte = (frame_pos == FRAME_START_HI || frame_pos == FRAME_END_HI) ?
                         word[15:8] : word[7:0];
         if (frame_pos >= FRAME_END_LO) begin
            res.frame_end = 1'b1;
            frame_pos     = FRAME_OPCODE;
            if (phase_q == FILL_ROW_RESTORE) begin
               res.last = 1'b1;
               phase_q  = FILL_IDLE;
            end else begin
               phase_q = fill_phase_type'(phase_q + 3'd1);
            end
         end else begin
            frame_pos = frame_pos + 1'b1;
         end
      end
      return 1'b1;
   endfunction

   // Sample all three channels at the rising edge; compare before predicting,
   // since a byte leaving now belongs to an earlier slot.
   always @(posedge clock) begin
      lrf_item_type   item;
      lrf_result_type got;
      lrf_result_type want;
      lrf_result_type predicted;
      if (reset) begin
         phase_q       = FILL_IDLE;
         frame_pos     = FRAME_OPCODE;
         pixels_left   = '0;
         low_half_next = 1'b0;
         win_x         = '0;
         win_y         = '0;
         win_wm1       = '0;
         win_hm1       = '0;
         color_q       = '0;
         panel_width   = SCREEN_WIDTH_RESET;
         panel_height  = SCREEN_HEIGHT_RESET;
         owed_queue.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_SCREEN_WIDTH:  panel_width  = csr_mon.data;
               CSR_SCREEN_HEIGHT: panel_height = csr_mon.data;
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.link_byte  = rsp_mon.link_byte;
            got.is_command = rsp_mon.is_command;
            got.frame_end  = rsp_mon.frame_end;
            got.last       = rsp_mon.last;
            if (owed_queue.size() == 0) begin
               report_mismatch($sformatf("byte %h with nothing owed", got.link_byte));
            end else begin
               want = owed_queue.pop_front();
               if (got.link_byte !== want.link_byte)
                  report_mismatch($sformatf("link_byte %h, wanted %h",
                                            got.link_byte, want.link_byte));
               if (got.is_command !== want.is_command)
                  report_mismatch($sformatf("is_command %b, wanted %b",
                                            got.is_command, want.is_command));
               if (got.frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %b, wanted %b",
                                            got.frame_end, want.frame_end));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            item.command     = req_mon.command;
            item.rect_x      = req_mon.rect_x;
            item.rect_y      = req_mon.rect_y;
            item.rect_width  = req_mon.rect_width;
            item.rect_height = req_mon.rect_height;
            item.fill_color  = req_mon.fill_color;
            if (next_link_byte(item, predicted))
               owed_queue.push_back(predicted);
         end
      end
      owed_bytes <= owed_queue.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives rectangle fills through the LCD fill sequencer: directed corner
// rectangles first, then random small fills under several panel sizes, with
// ignored starts and idle slots mixed in, bursty requests and a stalling
// response side. The stream check beside the block does all the comparing.
// ----------------------------------------------------------------------------
module testbench;
   import lrf_pkg::*;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int ITEMS_PER_PHASE  = 310;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int ADDR_FRAME_BYTES = 5;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int   failures;
   int   owed_bytes;
   int   cycle_count;
   int   fill_items;
   int   burst_left;
   bit   steady_sender;
   bit   long_hold_req;

   lrf_req_if req_bus ();
   lrf_rsp_if rsp_bus ();
   lrf_csr_if csr_bus ();

   lcd_rect_fill_sequencer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   lrf_stream_check stream_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .failures   (failures),
      .owed_bytes (owed_bytes)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // drop the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Response side: stall on a changing pattern, and hold off for a long
   // stretch whenever asked.
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      int          tick;
      mode      = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      tick      = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (long_hold_req && hold_left == 0) begin
            hold_left     = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
               default:   rsp_bus.ready <= ((tick % 7) >= 3);
            endcase
         end
      end
   end

   function automatic lrf_item_type random_item();
      lrf_item_type it;
      it.command     = 1'($urandom_range(0, 1));
      it.rect_x      = COORD_W'($urandom);
      it.rect_y      = COORD_W'($urandom);
      it.rect_width  = SIZE_W'($urandom);
      it.rect_height = SIZE_W'($urandom);
      it.fill_color  = COLOR_W'($urandom);
      return it;
   endfunction

   function automatic lrf_item_type slot_item();
      lrf_item_type it;
      it         = random_item();
      it.command = CMD_SLOT;
      return it;
   endfunction

   // mostly 1..4 pixels, at times with bit 10 set so it wraps to the same size
   function automatic logic [SIZE_W-1:0] small_size();
      return SIZE_W'($urandom_range(1, 4) + (($urandom_range(0, 3) == 0) ? 1024 : 0));
   endfunction

   function automatic lrf_item_type start_item(input int x, input int y, input int w,
                                               input int h, input int color);
      lrf_item_type it;
      it.command     = CMD_START;
      it.rect_x      = COORD_W'(x);
      it.rect_y      = COORD_W'(y);
      it.rect_width  = SIZE_W'(w);
      it.rect_height = SIZE_W'(h);
      it.fill_color  = COLOR_W'(color);
      return it;
   endfunction

   // Offer one item at the falling edge and hold it until taken; then close
   // the burst with a random gap if it has run out.
   task automatic offer_item(input lrf_item_type it);
      req_bus.valid       <= 1'b1;
      req_bus.command     <= it.command;
      req_bus.rect_x      <= it.rect_x;
      req_bus.rect_y      <= it.rect_y;
      req_bus.rect_width  <= it.rect_width;
      req_bus.rect_height <= it.rect_height;
      req_bus.fill_color  <= it.fill_color;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      if (!steady_sender) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // stop offering and wait until every owed byte is back
   task automatic drain_bytes();
      req_bus.valid <= 1'b0;
      wait (owed_bytes == 0);
      @(negedge clock);
   endtask

   // Start a fill and feed exactly the slots it needs. Optionally throw in
   // ignored starts, a long receiver hold-off or a mid-fill drain.
   task automatic run_fill(input lrf_item_type first, input int busy_start_odds,
                           input bit hold_midway, input bit drain_midway);
      logic [SIZE_W-1:0] wm1;
      logic [SIZE_W-1:0] hm1;
      int                pixel_count;
      int                slots;
      lrf_item_type      stray;
      wm1         = first.rect_width - 1'b1;
      hm1         = first.rect_height - 1'b1;
      pixel_count = (int'(wm1[COORD_W-1:0]) + 1) * (int'(hm1[COORD_W-1:0]) + 1);
      slots       = 4 * ADDR_FRAME_BYTES + 1 + 2 * pixel_count;
      offer_item(first);
      fill_items++;
      for (int n = 0; n < slots; n++) begin
         if (busy_start_odds > 0 && $urandom_range(0, busy_start_odds - 1) == 0) begin
            stray         = random_item();
            stray.command = CMD_START;
            offer_item(stray);
         end
         if (hold_midway && n == 3)
            long_hold_req = 1'b1;
         if (drain_midway && n == slots / 2)
            drain_bytes();
         offer_item(slot_item());
         fill_items++;
      end
   endtask

   // write both panel registers while the block is idle
   task automatic set_panel(input int width, input int height);
      drain_bytes();
      repeat (4) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_SCREEN_WIDTH;
      csr_bus.data  <= CSR_DATA_W'(width);
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.index <= CSR_SCREEN_HEIGHT;
      csr_bus.data  <= CSR_DATA_W'(height);
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      lrf_item_type first;
      int           phase_start;
      int           panel_w[5];
      int           panel_h[5];

      req_bus.valid       <= 1'b0;
      req_bus.command     <= CMD_START;
      req_bus.rect_x      <= '0;
      req_bus.rect_y      <= '0;
      req_bus.rect_width  <= '0;
      req_bus.rect_height <= '0;
      req_bus.fill_color  <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= CSR_SCREEN_WIDTH;
      csr_bus.data        <= '0;
      burst_left    = 0;
      steady_sender = 1'b0;
      long_hold_req = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under the reset panel size
      offer_item(slot_item());                                   // slot while idle
      run_fill(start_item(0, 0, 1, 1, 'h0000), 1, 1'b0, 1'b0);    // start before every slot
      offer_item(slot_item());
      run_fill(start_item(1023, 1023, 1025, 1025, 'hFFFF), 0, 1'b0, 1'b0); // sizes wrap to 1
      run_fill(start_item(1023, 0, 4, 2, 'hA5A5), 0, 1'b0, 1'b0);  // column end past 1023
      run_fill(start_item(0, 1023, 2, 3, 'h5A5A), 0, 1'b0, 1'b0);  // row end past 1023

      // random fills under a range of panel sizes, extremes included
      panel_w = '{1, 1024, 0, 2047, $urandom_range(1, 1024)};
      panel_h = '{1, 1024, 0, 2047, $urandom_range(1, 1024)};
      for (int p = 0; p < 5; p++) begin
         set_panel(panel_w[p], panel_h[p]);
         steady_sender = (p == 3);
         phase_start   = fill_items;
         while (fill_items - phase_start < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 5) == 0)
               offer_item(slot_item());
            first             = random_item();
            first.command     = CMD_START;
            first.rect_width  = small_size();
            first.rect_height = small_size();
            if ($urandom_range(0, 19) == 0)
               first.rect_width = SIZE_W'($urandom_range(5, 16));
            run_fill(first, ($urandom_range(0, 2) == 0) ? 6 : 0,
                     (p == 1 && fill_items == phase_start),
                     (p == 2 && fill_items == phase_start));
         end
      end

      // let the last bytes out, then give the verdict
      drain_bytes();
      repeat (10) @(negedge clock);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
